### rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(lbl, clk_i, rstn_i, ante, cons) \
    lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons) \
    lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### rtl/sdrsp_pkg.sv
package sdrsp_pkg;

    localparam logic [1:0] RT_R1 = 2'd0;
    localparam logic [1:0] RT_R2 = 2'd1;
    localparam logic [1:0] RT_R3 = 2'd2;
    localparam logic [1:0] RT_R6 = 2'd3;

    localparam logic ACT_BEGIN = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BUSY    = 2'd1;
    localparam logic [1:0] ST_CRC     = 2'd2;
    localparam logic [1:0] ST_TIMEOUT = 2'd3;

    localparam logic [4:0] LONG_LAST_IDX  = 5'd16;
    localparam logic [4:0] SHORT_LAST_IDX = 5'd5;
    localparam logic [4:0] CRC_BYTES      = 5'd5;
    localparam logic [6:0] CRC_POLY       = 7'h09;
    localparam logic [9:0] TIMEOUT_RESET  = 10'd101;

    typedef struct packed {
        logic [4:0] byte_index;
        logic [7:0] byte_value;
        logic       last;
        logic [1:0] status;
    } result_t;

    function automatic logic [6:0] crc7_step(input logic [6:0] crc, input logic bit_in);
        logic fb;
        fb = crc[6] ^ bit_in;
        return {crc[5:0], 1'b0} ^ (fb ? CRC_POLY : 7'h00);
    endfunction

endpackage

### rtl/sd_response_receiver_crc7_unit.sv
// A byte result goes to the output register, or to the skid register if the output is held.
// Throughput: one transaction per cycle while in_stall is low; the FSM adds no waits.
// Input stalls only while both output stages hold results that have not been taken.
// Reset (asynchronous, active low): idle, all counters and CRC cleared,
// start_timeout set to 101, output stages empty.
`include "assert_macros.svh"

module sd_response_receiver_crc7_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [9:0] cfg_wr_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       action,
    input  logic [1:0] response_type,
    input  logic       cmd_bit,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [4:0] byte_index,
    output logic [7:0] byte_value,
    output logic       last,
    output logic [1:0] status
);
    import sdrsp_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_WAIT = 2'd1,
        PH_RECV = 2'd2
    } phase_t;

    logic [9:0] start_timeout_reg;
    phase_t     phase_reg, phase_next;
    logic [1:0] kind_reg, kind_next;
    logic [9:0] wait_count_reg, wait_count_next;
    logic [4:0] byte_count_reg, byte_count_next;
    logic [2:0] bit_count_reg, bit_count_next;
    logic [7:0] shift_byte_reg, shift_byte_next;
    logic [6:0] crc_reg, crc_next;
    logic       busy_seen_reg, busy_seen_next;

    logic       in_fire;
    logic       res_push;
    result_t    res;
    result_t    out_data;
    logic       skid_full;
    logic [7:0] shifted;
    logic [7:0] crc_expect;
    logic       fin;

    assign in_stall = skid_full;
    assign in_fire  = in_valid && !skid_full;
    assign shifted  = {shift_byte_reg[6:0], cmd_bit};
    assign fin      = (kind_reg == RT_R2) ? (byte_count_reg >= LONG_LAST_IDX)
                                          : (byte_count_reg >= SHORT_LAST_IDX);

    always_comb
    begin
        phase_next      = phase_reg;
        kind_next       = kind_reg;
        wait_count_next = wait_count_reg;
        byte_count_next = byte_count_reg;
        bit_count_next  = bit_count_reg;
        shift_byte_next = shift_byte_reg;
        crc_next        = crc_reg;
        busy_seen_next  = busy_seen_reg;
        crc_expect      = 8'h00;
        res_push        = 1'b0;
        res             = '0;

        if (in_fire)
        begin
            if (action == ACT_BEGIN)
            begin
                phase_next      = PH_WAIT;
                kind_next       = response_type;
                wait_count_next = '0;
                byte_count_next = '0;
                bit_count_next  = '0;
                shift_byte_next = '0;
                crc_next        = '0;
                busy_seen_next  = 1'b0;
            end
            else
            begin
                unique case (phase_reg)
                    PH_WAIT:
                    begin
                        if (!cmd_bit)
                        begin
                            phase_next      = PH_RECV;
                            shift_byte_next = '0;
                            bit_count_next  = 3'd1;
                            crc_next        = crc7_step(crc_reg, 1'b0);
                        end
                        else if (wait_count_reg >= start_timeout_reg)
                        begin
                            phase_next     = PH_IDLE;
                            res_push       = 1'b1;
                            res.byte_index = '0;
                            res.byte_value = '0;
                            res.last       = 1'b1;
                            res.status     = ST_TIMEOUT;
                        end
                        else
                        begin
                            wait_count_next = wait_count_reg + 10'd1;
                        end
                    end
                    PH_RECV:
                    begin
                        shift_byte_next = shifted;
                        if (byte_count_reg < CRC_BYTES)
                        begin
                            crc_next = crc7_step(crc_reg, cmd_bit);
                        end
                        if (bit_count_reg != 3'd7)
                        begin
                            bit_count_next = bit_count_reg + 3'd1;
                        end
                        else
                        begin
                            bit_count_next  = '0;
                            shift_byte_next = '0;
                            if (kind_reg == RT_R3 && byte_count_reg == 5'd1 && !shifted[7])
                            begin
                                busy_seen_next = 1'b1;
                            end
                            crc_expect     = {crc_next, 1'b1};
                            res_push       = 1'b1;
                            res.byte_index = byte_count_reg;
                            res.byte_value = shifted;
                            res.last       = fin;
                            res.status     = ST_OK;
                            if (fin)
                            begin
                                if (kind_reg == RT_R3 && busy_seen_next)
                                begin
                                    res.status = ST_BUSY;
                                end
                                if ((kind_reg == RT_R1 || kind_reg == RT_R6)
                                    && shifted != crc_expect)
                                begin
                                    res.status = ST_CRC;
                                end
                                phase_next = PH_IDLE;
                            end
                            byte_count_next = byte_count_reg + 5'd1;
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_timeout_reg <= TIMEOUT_RESET;
            phase_reg         <= PH_IDLE;
            kind_reg          <= '0;
            wait_count_reg    <= '0;
            byte_count_reg    <= '0;
            bit_count_reg     <= '0;
            shift_byte_reg    <= '0;
            crc_reg           <= '0;
            busy_seen_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                start_timeout_reg <= cfg_wr_data;
            end
            phase_reg      <= phase_next;
            kind_reg       <= kind_next;
            wait_count_reg <= wait_count_next;
            byte_count_reg <= byte_count_next;
            bit_count_reg  <= bit_count_next;
            shift_byte_reg <= shift_byte_next;
            crc_reg        <= crc_next;
            busy_seen_reg  <= busy_seen_next;
        end
    end

    sdrsp_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res),
        .full      (skid_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign byte_index = out_data.byte_index;
    assign byte_value = out_data.byte_value;
    assign last       = out_data.last;
    assign status     = out_data.status;

    `ASSERT_NEXT(a_last_goes_idle, clk, rst_n, res_push && res.last, phase_reg == PH_IDLE)
    `ASSERT_IMPL(a_bits_only_in_recv, clk, rst_n, bit_count_reg != 3'd0, phase_reg == PH_RECV)

endmodule

### rtl/sdrsp_skid.sv
`include "assert_macros.svh"

module sdrsp_skid (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  sdrsp_pkg::result_t push_data,
    output logic              full,
    output logic              out_valid,
    input  logic              out_stall,
    output sdrsp_pkg::result_t out_data
);
    import sdrsp_pkg::*;

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;
    logic    pop;

    assign pop       = out_valid_reg && !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_reg   <= skid_data_reg;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_data_reg  <= push_data;
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_data_reg  <= push_data;
                skid_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    `ASSERT_IMPL(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg)
    `ASSERT_IMPL(a_no_push_when_full, clk, rst_n, push, !skid_valid_reg)

endmodule
